[rtl/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // fixed field widths of the words on the ports
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 3;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              new_string;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

[rtl/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over NUM_FRAMES frames, one page reference per word.
// ----------------------------------------------------------------------------
// Flow: an accepted word is scanned over the n frames in use
// (1..NUM_FRAMES), then the update state registers the result word. One
// reference is handled at a time; the update waits while the result is held.
// The frame scan reads one page per cycle through the page store's read port.
// Reset: synchronous active-low aresetn clears all frames and sets the frame
// count to 8; page contents are not cleared.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int RW = IW;
    localparam logic [RW-1:0] RANK_MAX   = RW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FRAMES_ALL = CW'(NUM_FRAMES);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     cfg_reg;
    logic [CW-1:0]        n_act;

    logic [NUM_FRAMES-1:0] valid_reg;
    logic [RW-1:0]         rank_reg [NUM_FRAMES];

    logic [PAGE_BITS-1:0] key_reg;
    logic [PAGE_BITS-1:0] key_in;
    logic [CW-1:0]        idx_reg;
    logic                 cmp_valid_reg;
    logic [IW-1:0]        cmp_idx_reg;

    logic                 hit_reg;
    logic [IW-1:0]        hit_idx_reg;
    logic [RW-1:0]        hit_rank_reg;
    logic                 empty_reg;
    logic [IW-1:0]        empty_idx_reg;
    logic [RW-1:0]        best_rank_reg;
    logic [IW-1:0]        vict_idx_reg;
    logic [PAGE_BITS-1:0] vict_page_reg;

    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    logic                 accept;
    logic                 rd_en;
    logic                 out_free;
    logic                 upd_fire;
    logic                 scan_last;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 match;
    logic                 cur_valid;
    logic [RW-1:0]        cur_rank;
    logic [IW-1:0]        upd_f;
    logic [CW-1:0]        upd_limit;
    logic                 upd_evict;
    logic [FRAME_W-1:0]   upd_fidx;
    logic [PAGE_W-1:0]    upd_evpage;

    // frames in use: zero acts as one, clamp at NUM_FRAMES
    always_comb begin
        if (cfg_reg == '0) begin
            n_act = CW'(1);
        end else if (int'(cfg_reg) > NUM_FRAMES) begin
            n_act = FRAMES_ALL;
        end else begin
            n_act = CW'(cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign rd_en     = (state_reg == ST_SCAN) && (idx_reg < n_act);
    assign out_free  = !m_valid_reg || m_ready;
    assign upd_fire  = (state_reg == ST_UPDATE) && out_free;
    assign scan_last = cmp_valid_reg && (CW'(cmp_idx_reg) == n_act - CW'(1));
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_rank  = rank_reg[cmp_idx_reg];

    // page key on its low PAGE_BITS bits, zero-extended when wider
    always_comb begin
        key_in = '0;
        for (int b = 0; b < PAGE_BITS; b++) begin
            if (b < PAGE_W) begin
                key_in[b] = s_data.page_number[b % PAGE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    lrupr_page_store #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IW-1:0]),
        .key     (key_reg),
        .wr_en   (upd_fire && !hit_reg),
        .wr_addr (upd_f),
        .wr_data (key_reg),
        .rd_page (rd_page),
        .match   (match)
    );

    // scan pipeline: issue read, then compare in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= rd_en;
            if (accept) begin
                idx_reg <= '0;
            end else if (rd_en) begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg   <= key_in;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        if (rd_en) begin
            cmp_idx_reg <= idx_reg[IW-1:0];
        end
        if (cmp_valid_reg) begin
            // lowest matching frame wins
            if (cur_valid && match && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= cmp_idx_reg;
                hit_rank_reg <= cur_rank;
            end
            // ascending scan, so the last empty seen is the highest
            if (!cur_valid) begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= cmp_idx_reg;
            end
            // oldest frame, lowest index on a tie
            if (cmp_idx_reg == '0 || cur_rank > best_rank_reg) begin
                best_rank_reg <= cur_rank;
                vict_idx_reg  <= cmp_idx_reg;
                vict_page_reg <= rd_page;
            end
        end
    end

    always_comb begin
        if (hit_reg) begin
            upd_f     = hit_idx_reg;
            upd_limit = CW'(hit_rank_reg);
        end else if (empty_reg) begin
            upd_f     = empty_idx_reg;
            upd_limit = FRAMES_ALL;
        end else begin
            upd_f     = vict_idx_reg;
            upd_limit = CW'(best_rank_reg);
        end
        upd_evict = !hit_reg && !empty_reg;

        upd_fidx = '0;
        for (int b = 0; b < FRAME_W; b++) begin
            if (b < IW) begin
                upd_fidx[b] = upd_f[b % IW];
            end
        end

        upd_evpage = '0;
        for (int b = 0; b < PAGE_W; b++) begin
            if (b < PAGE_BITS && upd_evict) begin
                upd_evpage[b] = vict_page_reg[b % PAGE_BITS];
            end
        end
    end

    // frame valid and age ranks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (accept && s_data.new_string) begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (upd_fire) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (IW'(i) == upd_f) begin
                    rank_reg[i] <= '0;
                end else if (i < int'(n_act) && valid_reg[i]
                             && CW'(rank_reg[i]) < upd_limit
                             && rank_reg[i] != RANK_MAX) begin
                    rank_reg[i] <= rank_reg[i] + RW'(1);
                end
            end
            valid_reg[upd_f] <= 1'b1;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (upd_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_fire) begin
            m_data_reg.hit           <= hit_reg;
            m_data_reg.frame_index   <= upd_fidx;
            m_data_reg.evicted_valid <= upd_evict;
            m_data_reg.evicted_page  <= upd_evpage;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a reference is in progress");

    a_update_issues_word : assert property (@(posedge aclk) disable iff (!aresetn)
        upd_fire |=> m_valid)
        else $error("update finished without a result word");

    a_hit_no_evict : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.hit && m_data.evicted_valid))
        else $error("hit word reports an eviction");

    a_evict_page_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.evicted_valid) |-> (m_data.evicted_page == '0))
        else $error("evicted page nonzero without an eviction");

endmodule

[rtl/lrupr_page_store.sv]
// ----------------------------------------------------------------------------
// lrupr_page_store
// Page number per frame: one write port, one registered read port, and the
// shared comparator that matches the read page against the lookup key.
// ----------------------------------------------------------------------------
module lrupr_page_store
    import lrupr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
    input  logic [PAGE_BITS-1:0]          key,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_FRAMES)-1:0] wr_addr,
    input  logic [PAGE_BITS-1:0]          wr_data,
    output logic [PAGE_BITS-1:0]          rd_page,
    output logic                          match
);

    logic [PAGE_BITS-1:0] mem [NUM_FRAMES];
    logic [PAGE_BITS-1:0] rd_page_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_page_reg <= mem[rd_addr];
        end
    end

    assign rd_page = rd_page_reg;
    assign match   = (rd_page_reg == key);

endmodule

[tb/lru_page_replacement_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Self-checking bench for the LRU page replacement block. Page references are
// driven over the input channel while a local model of the frame table
// predicts hit, frame and eviction for every word. Returned words are checked
// field by field in order. The run covers directed fills, hits and evictions,
// the frame count extremes, and random reference streams over small page pools
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;
    import lrupr_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_word_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_word_t        m_data;

    // local copy of the frame table
    logic [PAGE_W-1:0] frame_page [NUM_FRAMES_DEF];
    bit                frame_held [NUM_FRAMES_DEF];
    int                frame_rank [NUM_FRAMES_DEF];
    logic [CFG_W-1:0]  frame_limit;

    out_word_t expected_outcomes [$];
    int        mismatch_count = 0;
    bit        sender_no_gaps = 1'b0;
    bit        sink_no_stalls = 1'b0;
    int        stall_left = 0;

    lru_page_replacement DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Age valid frames in use that are younger than limit, then make f newest.
    function automatic void age_frames(input int n, input int f, input int limit);
        int i;
        for (i = 0; i < n; i++) begin
            if (i != f && frame_held[i] && frame_rank[i] < limit
                    && frame_rank[i] < NUM_FRAMES_DEF - 1) begin
                frame_rank[i]++;
            end
        end
        frame_rank[f] = 0;
    endfunction

    function automatic out_word_t predict_lookup(input in_word_t w);
        out_word_t r;
        int        n;
        int        f;
        int        best;
        int        i;
        bit        found;
        bit        empty;
        if (frame_limit == 0) begin
            n = 1;
        end else if (frame_limit > NUM_FRAMES_DEF) begin
            n = NUM_FRAMES_DEF;
        end else begin
            n = int'(frame_limit);
        end
        r = '0;
        f = 0;
        found = 1'b0;
        empty = 1'b0;
        if (w.new_string) begin
            for (i = 0; i < NUM_FRAMES_DEF; i++) begin
                frame_held[i] = 1'b0;
                frame_rank[i] = 0;
            end
        end
        for (i = 0; i < n && !found; i++) begin
            if (frame_held[i] && frame_page[i] == w.page_number) begin
                f = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            age_frames(n, f, frame_rank[f]);
        end else begin
            // empty frames fill from the top index down
            for (i = n - 1; i >= 0 && !empty; i--) begin
                if (!frame_held[i]) begin
                    f = i;
                    empty = 1'b1;
                end
            end
            if (empty) begin
                age_frames(n, f, NUM_FRAMES_DEF);
            end else begin
                // oldest rank loses, lowest index on a tie
                best = frame_rank[0];
                f = 0;
                for (i = 1; i < n; i++) begin
                    if (frame_rank[i] > best) begin
                        best = frame_rank[i];
                        f = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_page[f];
                age_frames(n, f, best);
            end
            frame_page[f] = w.page_number;
            frame_held[f] = 1'b1;
        end
        r.frame_index = 3'(f);
        return r;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [PAGE_W-1:0] want,
                                        input logic [PAGE_W-1:0] got);
        if (got !== want) begin
            log_mismatch($sformatf("%s expected %h got %h", name, want, got));
        end
    endfunction

    // result side: check each word, then stall the sink at random
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    log_mismatch($sformatf("unexpected word %h", m_data));
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("hit", PAGE_W'(want.hit), PAGE_W'(m_data.hit));
                    check_field("frame_index", PAGE_W'(want.frame_index),
                                PAGE_W'(m_data.frame_index));
                    check_field("evicted_valid", PAGE_W'(want.evicted_valid),
                                PAGE_W'(m_data.evicted_valid));
                    check_field("evicted_page", want.evicted_page, m_data.evicted_page);
                end
                stall_left = sink_no_stalls ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Returns on the accepting edge with s_valid still high; in that same step the
    // next call lowers it or drives the next word, or settle() lowers it.
    task automatic send_ref(input logic [PAGE_W-1:0] page, input logic fresh);
        int       gap;
        in_word_t w;
        gap = sender_no_gaps ? 0 : $urandom_range(0, 8);
        w.page_number = page;
        w.new_string = fresh;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        expected_outcomes.push_back(predict_lookup(w));
    endtask

    // hold off the sender until every outstanding word is back and the block is idle
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_outcomes.size() != 0 || !s_ready);
        @(posedge aclk);
    endtask

    task automatic set_frame_count(input logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_limit = value;
    endtask

    task automatic test_fill_and_evict();
        send_ref(16'h0000, 1'b1);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h00FF, 1'b0);
        send_ref(16'h0000, 1'b0);   // hit refreshes frame 7
        send_ref(16'hBEEF, 1'b0);   // evicts the oldest page
        send_ref(16'hAAAA, 1'b1);   // restart: table cleared first
    endtask

    task automatic test_frame_count_limits();
        set_frame_count(4'd0);      // behaves as one frame
        send_ref(16'h0011, 1'b0);
        send_ref(16'h0022, 1'b0);
        set_frame_count(4'd15);     // clamps to all frames
        send_ref(16'hAAAA, 1'b0);   // frame outside the old count kept its page
        send_ref(16'h0033, 1'b0);
        set_frame_count(4'd2);
        send_ref(16'h0044, 1'b0);
        send_ref(16'h0022, 1'b0);
        send_ref(16'h0055, 1'b0);
        set_frame_count(4'd8);
        send_ref(16'h0066, 1'b0);
        send_ref(16'h0044, 1'b1);
        set_frame_count(4'd1);
        send_ref(16'h0077, 1'b1);
        send_ref(16'h0077, 1'b0);
    endtask

    task automatic test_random_references();
        logic [PAGE_W-1:0] pool [16];
        logic [CFG_W-1:0]  count;
        int                sent;
        int                phase_len;
        int                pool_size;
        int                k;
        sent = 0;
        while (sent < 550) begin
            if ($urandom_range(0, 9) < 3) begin
                count = 4'($urandom_range(0, 15));
            end else begin
                count = 4'($urandom_range(1, 8));
            end
            set_frame_count(count);
            sender_no_gaps = ($urandom_range(0, 3) == 0);
            sink_no_stalls = ($urandom_range(0, 3) == 0);
            // a pool of up to twelve pages against up to eight frames gives hits and evictions
            pool_size = $urandom_range(1, 12);
            for (k = 0; k < pool_size; k++) begin
                pool[k] = 16'($urandom);
            end
            phase_len = $urandom_range(20, 60);
            for (k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_ref(16'($urandom), $urandom_range(0, 29) == 0);
                end else begin
                    send_ref(pool[$urandom_range(0, pool_size - 1)],
                             $urandom_range(0, 29) == 0);
                end
            end
            sent += phase_len;
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_FRAMES_DEF; i++) begin
            frame_page[i] = '0;
            frame_held[i] = 1'b0;
            frame_rank[i] = 0;
        end
        frame_limit = CFG_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_fill_and_evict();
        test_frame_count_limits();
        test_random_references();

        settle();
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("lru_page_replacement test passed");
        end else begin
            $display("lru_page_replacement test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lru_page_replacement test failed");
        $finish;
    end

endmodule
